@@ rtl/core/utf8cpd_pkg.sv @@
// Package for the UTF-8 code point decoder: widths, byte masks and lead byte codes.
// Used by utf8_code_point_decoder_top and utf8cpd_checker; depends on nothing else.
package utf8cpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned OWED_W  = 2;
    localparam int unsigned CP_BYTES_W = 24;   // code point padded to whole bytes

    // Lead byte masks and patterns
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

    // Payload masks
    localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;

    // Continuation bytes still due
    typedef enum logic [OWED_W-1:0] {
        OWED_NONE  = 2'd0,
        OWED_ONE   = 2'd1,
        OWED_TWO   = 2'd2,
        OWED_THREE = 2'd3
    } owed_t;

endpackage

@@ rtl/core/utf8_code_point_decoder_top.sv @@
// UTF-8 to code point decoder, top level.
// Depends on utf8cpd_pkg.
//
// Takes one UTF-8 byte per beat (tlast marks the final byte of a string) and
// gives one 21-bit code point per completed sequence, with tlast set when the
// sequence was closed by the final byte. Invalid lead bytes and sequences cut
// short by the end of a string give no beat; decode state clears after every
// final byte. No range or overlong checks are made. An input register feeds
// a single decode step whose result lands in an output register, so a byte is
// taken every cycle; a code point reaches the output through those two
// registers. Downstream backpressure stalls the input only while the output
// register holds a beat that is not being taken.
module utf8_code_point_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_axis_tlast    // closes_text
);

    localparam int unsigned BYTE_W = utf8cpd_pkg::BYTE_W;
    localparam int unsigned CP_W   = utf8cpd_pkg::CP_W;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Decode state
    logic [CP_W-1:0]         partial_reg, partial_next;
    utf8cpd_pkg::owed_t      owed_reg, owed_next;

    // Output register
    logic            out_valid_reg, out_valid_next;
    logic [CP_W-1:0] out_cp_reg, out_cp_next;
    logic            out_last_reg;

    logic advance;
    logic emit;
    logic [CP_W-1:0] shifted;

    function automatic logic [BYTE_W-1:0] s_axis_tdata_mask(input logic [BYTE_W-1:0] b);
        s_axis_tdata_mask = b & utf8cpd_pkg::CONT_BITS;
    endfunction

    // Decode step moves when the input register holds a byte and the output register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign shifted = {partial_reg[CP_W-7:0], 6'b0}
                   | CP_W'(s_axis_tdata_mask(in_byte_reg));

    // Decode of one byte against the open sequence
    always_comb
    begin
        emit         = 1'b0;
        out_cp_next  = shifted;
        partial_next = partial_reg;
        owed_next    = owed_reg;
        case (owed_reg)
            utf8cpd_pkg::OWED_NONE:
            begin
                if ((in_byte_reg & utf8cpd_pkg::ASCII_MASK) == '0)
                begin
                    emit        = 1'b1;
                    out_cp_next = CP_W'(in_byte_reg);
                end
                else if ((in_byte_reg & utf8cpd_pkg::LEAD2_MASK) == utf8cpd_pkg::LEAD2_PAT)
                begin
                    partial_next = CP_W'(in_byte_reg & utf8cpd_pkg::LEAD2_BITS);
                    owed_next    = utf8cpd_pkg::OWED_ONE;
                end
                else if ((in_byte_reg & utf8cpd_pkg::LEAD3_MASK) == utf8cpd_pkg::LEAD3_PAT)
                begin
                    partial_next = CP_W'(in_byte_reg & utf8cpd_pkg::LEAD3_BITS);
                    owed_next    = utf8cpd_pkg::OWED_TWO;
                end
                else if ((in_byte_reg & utf8cpd_pkg::LEAD4_MASK) == utf8cpd_pkg::LEAD4_PAT)
                begin
                    partial_next = CP_W'(in_byte_reg & utf8cpd_pkg::LEAD4_BITS);
                    owed_next    = utf8cpd_pkg::OWED_THREE;
                end
            end
            utf8cpd_pkg::OWED_ONE:
            begin
                emit         = 1'b1;
                partial_next = '0;
                owed_next    = utf8cpd_pkg::OWED_NONE;
            end
            utf8cpd_pkg::OWED_TWO:
            begin
                partial_next = shifted;
                owed_next    = utf8cpd_pkg::OWED_ONE;
            end
            utf8cpd_pkg::OWED_THREE:
            begin
                partial_next = shifted;
                owed_next    = utf8cpd_pkg::OWED_TWO;
            end
            default:
            begin
                partial_next = '0;
                owed_next    = utf8cpd_pkg::OWED_NONE;
            end
        endcase

        // End of string drops any open sequence
        if (in_last_reg)
        begin
            partial_next = '0;
            owed_next    = utf8cpd_pkg::OWED_NONE;
        end
    end

    // Output valid: load on a decode step, else clear once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = emit;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            partial_reg   <= '0;
            owed_reg      <= utf8cpd_pkg::OWED_NONE;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                partial_reg <= partial_next;
                owed_reg    <= owed_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && emit)
        begin
            out_cp_reg   <= out_cp_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = utf8cpd_pkg::CP_BYTES_W'(out_cp_reg);
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ dv/utf8cpd_checker.sv @@
// Checker for the UTF-8 code point decoder: watches both stream sides, predicts
// every output beat from the accepted input bytes and compares in order.
// Depends on utf8cpd_pkg.
`timescale 1ns / 1ps

module utf8cpd_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          errors,
    output int          pending
);

    localparam int unsigned BYTE_W = utf8cpd_pkg::BYTE_W;
    localparam int unsigned CP_W   = utf8cpd_pkg::CP_W;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            closes_text;
    } cp_beat_t;

    // Decoder state mirror
    logic [CP_W-1:0]    acc_cp;
    utf8cpd_pkg::owed_t cont_owed;

    cp_beat_t expected_cps[$];
    int       mismatch_count;

    assign errors = mismatch_count;

    task automatic flag_mismatch(input string what, input logic [23:0] want,
                                 input logic [23:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH %s: expected %06h got %06h", what, want, got);
    endtask

    // One byte through the decode step; a completed code point is queued
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eot);
        if (cont_owed == utf8cpd_pkg::OWED_NONE)
        begin
            if ((b & utf8cpd_pkg::ASCII_MASK) == '0)
            begin
                expected_cps.push_back('{code_point: CP_W'(b), closes_text: eot});
            end
            else if ((b & utf8cpd_pkg::LEAD2_MASK) == utf8cpd_pkg::LEAD2_PAT)
            begin
                acc_cp    = CP_W'(b & utf8cpd_pkg::LEAD2_BITS);
                cont_owed = utf8cpd_pkg::OWED_ONE;
            end
            else if ((b & utf8cpd_pkg::LEAD3_MASK) == utf8cpd_pkg::LEAD3_PAT)
            begin
                acc_cp    = CP_W'(b & utf8cpd_pkg::LEAD3_BITS);
                cont_owed = utf8cpd_pkg::OWED_TWO;
            end
            else if ((b & utf8cpd_pkg::LEAD4_MASK) == utf8cpd_pkg::LEAD4_PAT)
            begin
                acc_cp    = CP_W'(b & utf8cpd_pkg::LEAD4_BITS);
                cont_owed = utf8cpd_pkg::OWED_THREE;
            end
            // anything else is a bad lead byte and is dropped
        end
        else
        begin
            // continuation slot: low six bits only, top bits ignored
            acc_cp    = (acc_cp << 6) | CP_W'(b & utf8cpd_pkg::CONT_BITS);
            cont_owed = utf8cpd_pkg::owed_t'(cont_owed - 1'b1);
            if (cont_owed == utf8cpd_pkg::OWED_NONE)
            begin
                expected_cps.push_back('{code_point: acc_cp, closes_text: eot});
                acc_cp = '0;
            end
        end
        // end of string drops any open sequence
        if (eot)
        begin
            acc_cp    = '0;
            cont_owed = utf8cpd_pkg::OWED_NONE;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cp_beat_t want;
        if (!rst_n)
        begin
            acc_cp    = '0;
            cont_owed = utf8cpd_pkg::OWED_NONE;
            expected_cps.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_cps.size() == 0)
                begin
                    flag_mismatch("unexpected beat", 24'h0, m_tdata);
                end
                else
                begin
                    want = expected_cps.pop_front();
                    if (m_tdata !== {3'b000, want.code_point})
                        flag_mismatch("code_point", {3'b000, want.code_point}, m_tdata);
                    if (m_tlast !== want.closes_text)
                        flag_mismatch("closes_text", 24'(want.closes_text), 24'(m_tlast));
                end
            end
            pending <= expected_cps.size();
        end
    end

    initial mismatch_count = 0;

endmodule

@@ dv/tb_utf8_code_point_decoder_top.sv @@
// Testbench top for utf8_code_point_decoder_top: clock, reset, byte stimulus,
// output backpressure, idle watchdog and final verdict.
// Depends on utf8cpd_pkg, utf8_code_point_decoder_top and utf8cpd_checker.
`timescale 1ns / 1ps

module tb_utf8_code_point_decoder_top;

    localparam int IDLE_LIMIT = 4000;   // cycles with no beat on either side
    localparam int DRAIN_WAIT = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [20:0] code_point, [23:21] zero
    logic        m_axis_tlast;           // closes_text

    int errors;
    int pending;
    int src_gap_pct = 16;
    int sink_stall_pct = 70;
    int bytes_sent = 0;
    int idle_cycles = 0;

    utf8_code_point_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8cpd_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .s_tlast  (s_axis_tlast),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tlast  (m_axis_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Random output backpressure
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on stretches with no beat at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // One byte beat, with random gaps ahead of it; tvalid stays up afterwards
    task automatic send_beat(input logic [7:0] b, input logic eot);
        while ($urandom_range(99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        foreach (text[i])
            send_beat(text[i], i == text.size() - 1);
    endtask

    // Hold off the input until every expected code point has come out
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] cont_byte();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));   // lead-like junk in a continuation slot
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Mostly well-formed strings with random content, some noise and cut sequences
    task automatic send_random_text();
        logic [7:0] text[$];
        int units;
        int pick;
        int len;
        int conts;
        units = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 10);
        for (int u = 0; u < units; u++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                text.push_back({1'b0, 7'($urandom)});
            end
            else if (pick < 88)
            begin
                len = (pick < 55) ? 2 : (pick < 72) ? 3 : 4;
                text.push_back(lead_byte(len));
                for (int k = 1; k < len; k++)
                    text.push_back(cont_byte());
            end
            else if (pick < 94)
            begin
                text.push_back(8'($urandom_range(255)));
            end
            else
            begin
                // sequence short of its continuations
                len = $urandom_range(2, 4);
                conts = $urandom_range(0, len - 2);
                text.push_back(lead_byte(len));
                for (int k = 0; k < conts; k++)
                    text.push_back(cont_byte());
            end
        end
        // sometimes the string ends inside an open sequence
        if ($urandom_range(9) == 0)
        begin
            len = $urandom_range(2, 4);
            conts = $urandom_range(0, len - 2);
            text.push_back(lead_byte(len));
            for (int k = 0; k < conts; k++)
                text.push_back(cont_byte());
        end
        send_text(text);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ASCII extremes, each sequence length, bad leads, cut strings
        send_text('{8'h00, 8'h7F, 8'h41});
        send_text('{8'hC2, 8'hA9});
        send_text('{8'hE2, 8'h82, 8'hAC});
        send_text('{8'hF0, 8'h9F, 8'h98, 8'h80});
        send_text('{8'hF7, 8'hBF, 8'hBF, 8'hBF});           // largest 21-bit value
        send_text('{8'h80, 8'hBF, 8'hF8, 8'hFF});           // bad leads only
        send_text('{8'hC3, 8'hFF});                         // lead-like continuation
        send_text('{8'hE2, 8'h82});                         // cut by end of string
        send_text('{8'hC2});                                // lead as final byte
        send_text('{8'h5A});                                // state cleared after cut

        // Sender idles lightly, receiver heavily
        while (bytes_sent < 480)
            send_random_text();
        drain_outputs();

        // Sender idles heavily, receiver lightly
        src_gap_pct = 70;
        sink_stall_pct <= 16;
        while (bytes_sent < 960)
            send_random_text();
        drain_outputs();

        // No idling on either side
        src_gap_pct = 0;
        sink_stall_pct <= 0;
        while (bytes_sent < 1450)
            send_random_text();
        drain_outputs();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
